>>> rtl/tfna_pkg.sv
// types and constants shared by the triangle face normal and area unit
// no dependencies
package tfna_pkg;

   localparam int FRACTION_BITS_DEF = 16;
   localparam int COORD_W           = 32;
   localparam int TAG_W             = 16;
   localparam int LANES             = 3;
   localparam int EDGE_W            = COORD_W + 1;
   localparam int PROD_W            = 2 * EDGE_W;
   localparam int MAG_W             = PROD_W;
   localparam int SPLIT_W           = 32;
   localparam int HI_W              = MAG_W - SPLIT_W;
   localparam int RAD_W             = 2 * MAG_W;
   localparam int ROOT_W            = RAD_W / 2;
   localparam int REM_W             = ROOT_W + 1;
   localparam int NORM_FRAC         = 30;
   localparam int QUO_W             = NORM_FRAC + 1;
   localparam int DIV_R_W           = ROOT_W + 1;
   localparam int NORM_W            = 32;
   localparam int AREA_W            = 52;
   localparam int SQRT_CELLS        = ROOT_W;
   localparam int DIV_CELLS         = QUO_W;
   localparam int FRONT_STAGES      = 6;
   localparam int LATENCY           = FRONT_STAGES + SQRT_CELLS + DIV_CELLS + 1;

   typedef struct packed {
      logic [TAG_W-1:0]          face_tag;
      logic signed [COORD_W-1:0] ax;
      logic signed [COORD_W-1:0] ay;
      logic signed [COORD_W-1:0] az;
      logic signed [COORD_W-1:0] bx;
      logic signed [COORD_W-1:0] by_coord;
      logic signed [COORD_W-1:0] bz;
      logic signed [COORD_W-1:0] cx;
      logic signed [COORD_W-1:0] cy;
      logic signed [COORD_W-1:0] cz;
   } req_type;

   typedef struct packed {
      logic [TAG_W-1:0]         result_tag;
      logic signed [NORM_W-1:0] normal_x;
      logic signed [NORM_W-1:0] normal_y;
      logic signed [NORM_W-1:0] normal_z;
      logic [AREA_W-1:0]        area;
      logic                     degenerate;
   } rsp_type;

   // payload travelling through the square root cells
   typedef struct packed {
      logic [TAG_W-1:0]             tag;
      logic [LANES-1:0][MAG_W-1:0]  mag;
      logic [LANES-1:0]             neg;
      logic [RAD_W-1:0]             rad;
      logic [REM_W-1:0]             rem;
      logic [ROOT_W-1:0]            root;
   } sq_data_type;

   // payload travelling through the divider cells
   typedef struct packed {
      logic [TAG_W-1:0]               tag;
      logic [ROOT_W-1:0]              len;
      logic [LANES-1:0][DIV_R_W-1:0]  r;
      logic [LANES-1:0][QUO_W-1:0]    q;
      logic [LANES-1:0]               neg;
   } dv_data_type;

endpackage

>>> rtl/tfna_sqrt_cell.sv
// one cell of the integer square root chain: one root bit per cell
// depends on tfna_pkg
module tfna_sqrt_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  tfna_pkg::sq_data_type in_data,
   output logic                 out_valid,
   output tfna_pkg::sq_data_type out_data
);
   import tfna_pkg::*;

   logic        valid_ff;
   sq_data_type data_ff, data_in;
   logic [REM_W+1:0] trial, test;

   always_comb begin
      data_in     = in_data;
      trial       = {in_data.rem, in_data.rad[RAD_W-1 -: 2]};
      test        = (REM_W+2)'({in_data.root, 2'b01});
      data_in.rad = in_data.rad << 2;
      if (trial >= test) begin
         data_in.rem  = REM_W'(trial - test);
         data_in.root = {in_data.root[ROOT_W-2:0], 1'b1};
      end else begin
         data_in.rem  = REM_W'(trial);
         data_in.root = {in_data.root[ROOT_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> rtl/tfna_div_cell.sv
// one cell of the normalizing divider chain: one quotient bit per lane per cell
// depends on tfna_pkg
module tfna_div_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  tfna_pkg::dv_data_type in_data,
   output logic                 out_valid,
   output tfna_pkg::dv_data_type out_data
);
   import tfna_pkg::*;

   logic        valid_ff;
   dv_data_type data_ff, data_in;
   logic [LANES-1:0][DIV_R_W-1:0] rn;
   logic [LANES-1:0]              qb;

   always_comb begin
      data_in = in_data;
      for (int i = 0; i < LANES; i++) begin
         if (in_data.r[i] >= DIV_R_W'(in_data.len)) begin
            rn[i] = in_data.r[i] - DIV_R_W'(in_data.len);
            qb[i] = 1'b1;
         end else begin
            rn[i] = in_data.r[i];
            qb[i] = 1'b0;
         end
         data_in.r[i] = {rn[i][DIV_R_W-2:0], 1'b0};
         data_in.q[i] = {in_data.q[i][QUO_W-2:0], qb[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> rtl/triangle_face_normal_area_unit.sv
// triangle face normal and area: front stages, square root and divider chains
// depends on tfna_pkg, tfna_sqrt_cell, tfna_div_cell
//
// Takes one triangle in every clock cycle (busy stays low) and returns its
// result on a one-cycle rsp_valid strobe, in request order. The pipeline
// is made of six front stages (edges, edge products, cross product, split
// squares, per-lane squares, sum), a chain of 66 square root cells that each
// settle one bit of the 66-bit length, a chain of 31 divider cells that each
// settle one quotient bit of all three normal components, and one output
// register. The receiver cannot stall: every result must be taken in the
// cycle it is shown.
module triangle_face_normal_area_unit #(
   parameter int FRACTION_BITS = tfna_pkg::FRACTION_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  tfna_pkg::req_type req,
   output logic              rsp_valid,
   output tfna_pkg::rsp_type rsp
);
   import tfna_pkg::*;

   localparam int SHIFT = FRACTION_BITS + 1;

   logic [FRONT_STAGES-1:0] fv_ff;

   logic [TAG_W-1:0] tag0_ff, tag1_ff, tag2_ff, tag3_ff, tag4_ff, tag5_ff;
   logic signed [LANES-1:0][EDGE_W-1:0] e1_ff, e2_ff;
   logic signed [LANES-1:0][PROD_W-1:0] p_ff, q_ff;
   logic [LANES-1:0][MAG_W-1:0] mag2_ff, mag3_ff, mag4_ff, mag5_ff;
   logic [LANES-1:0]            neg2_ff, neg3_ff, neg4_ff, neg5_ff;
   logic [LANES-1:0][2*HI_W-1:0]        hh_ff;
   logic [LANES-1:0][HI_W+SPLIT_W-1:0]  hl_ff;
   logic [LANES-1:0][2*SPLIT_W-1:0]     ll_ff;
   logic [LANES-1:0][RAD_W-1:0]         sq_ff;
   logic [RAD_W-1:0]                    sum_ff;
   logic signed [LANES-1:0][PROD_W:0]   n_in;

   logic          sv [0:SQRT_CELLS];
   sq_data_type   sd [0:SQRT_CELLS];
   logic          dv [0:DIV_CELLS];
   dv_data_type   dd [0:DIV_CELLS];

   logic              rsp_valid_ff;
   rsp_type           rsp_ff, rsp_in;
   logic [LANES-1:0][QUO_W-1:0]  qr;
   logic [LANES-1:0][NORM_W-1:0] nrm;
   logic [ROOT_W-1:0]            len_sh;

   assign busy = 1'b0;

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         n_in[i] = {p_ff[i][PROD_W-1], p_ff[i]} - {q_ff[i][PROD_W-1], q_ff[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff <= '0;
      end else begin
         fv_ff <= {fv_ff[FRONT_STAGES-2:0], start};
      end
   end

   always_ff @(posedge clock) begin
      // edges from the first vertex
      tag0_ff  <= req.face_tag;
      e1_ff[0] <= {req.bx[COORD_W-1], req.bx} - {req.ax[COORD_W-1], req.ax};
      e1_ff[1] <= {req.by_coord[COORD_W-1], req.by_coord} - {req.ay[COORD_W-1], req.ay};
      e1_ff[2] <= {req.bz[COORD_W-1], req.bz} - {req.az[COORD_W-1], req.az};
      e2_ff[0] <= {req.cx[COORD_W-1], req.cx} - {req.ax[COORD_W-1], req.ax};
      e2_ff[1] <= {req.cy[COORD_W-1], req.cy} - {req.ay[COORD_W-1], req.ay};
      e2_ff[2] <= {req.cz[COORD_W-1], req.cz} - {req.az[COORD_W-1], req.az};
      // cross product terms
      tag1_ff <= tag0_ff;
      p_ff[0] <= $signed(e1_ff[1]) * $signed(e2_ff[2]);
      q_ff[0] <= $signed(e1_ff[2]) * $signed(e2_ff[1]);
      p_ff[1] <= $signed(e1_ff[2]) * $signed(e2_ff[0]);
      q_ff[1] <= $signed(e1_ff[0]) * $signed(e2_ff[2]);
      p_ff[2] <= $signed(e1_ff[0]) * $signed(e2_ff[1]);
      q_ff[2] <= $signed(e1_ff[1]) * $signed(e2_ff[0]);
      // sign and magnitude of each component
      tag2_ff <= tag1_ff;
      for (int i = 0; i < LANES; i++) begin
         neg2_ff[i] <= n_in[i][PROD_W];
         mag2_ff[i] <= n_in[i][PROD_W] ? MAG_W'(-n_in[i]) : MAG_W'(n_in[i]);
      end
      // squares split into partial products
      tag3_ff <= tag2_ff;
      mag3_ff <= mag2_ff;
      neg3_ff <= neg2_ff;
      for (int i = 0; i < LANES; i++) begin
         hh_ff[i] <= mag2_ff[i][MAG_W-1 -: HI_W] * mag2_ff[i][MAG_W-1 -: HI_W];
         hl_ff[i] <= mag2_ff[i][MAG_W-1 -: HI_W] * mag2_ff[i][SPLIT_W-1:0];
         ll_ff[i] <= mag2_ff[i][SPLIT_W-1:0] * mag2_ff[i][SPLIT_W-1:0];
      end
      tag4_ff <= tag3_ff;
      mag4_ff <= mag3_ff;
      neg4_ff <= neg3_ff;
      for (int i = 0; i < LANES; i++) begin
         sq_ff[i] <= (RAD_W'(hh_ff[i]) << (2 * SPLIT_W))
                   + (RAD_W'(hl_ff[i]) << (SPLIT_W + 1))
                   + RAD_W'(ll_ff[i]);
      end
      tag5_ff <= tag4_ff;
      mag5_ff <= mag4_ff;
      neg5_ff <= neg4_ff;
      sum_ff  <= sq_ff[0] + sq_ff[1] + sq_ff[2];
   end

   always_comb begin
      sv[0]      = fv_ff[FRONT_STAGES-1];
      sd[0].tag  = tag5_ff;
      sd[0].mag  = mag5_ff;
      sd[0].neg  = neg5_ff;
      sd[0].rad  = sum_ff;
      sd[0].rem  = '0;
      sd[0].root = '0;
   end

   for (genvar g = 0; g < SQRT_CELLS; g++) begin : g_sqrt
      tfna_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (sv[g]),
         .in_data   (sd[g]),
         .out_valid (sv[g+1]),
         .out_data  (sd[g+1])
      );
   end

   always_comb begin
      dv[0]     = sv[SQRT_CELLS];
      dd[0].tag = sd[SQRT_CELLS].tag;
      dd[0].len = sd[SQRT_CELLS].root;
      dd[0].neg = sd[SQRT_CELLS].neg;
      for (int i = 0; i < LANES; i++) begin
         dd[0].r[i] = DIV_R_W'(sd[SQRT_CELLS].mag[i]);
         dd[0].q[i] = '0;
      end
   end

   for (genvar g = 0; g < DIV_CELLS; g++) begin : g_div
      tfna_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (dv[g]),
         .in_data   (dd[g]),
         .out_valid (dv[g+1]),
         .out_data  (dd[g+1])
      );
   end

   always_comb begin
      // round half away from zero on the magnitude, then apply the sign
      for (int i = 0; i < LANES; i++) begin
         qr[i]  = dd[DIV_CELLS].q[i]
                + QUO_W'(dd[DIV_CELLS].r[i] >= DIV_R_W'(dd[DIV_CELLS].len));
         nrm[i] = dd[DIV_CELLS].neg[i] ? NORM_W'(-NORM_W'(qr[i])) : NORM_W'(qr[i]);
      end
      len_sh = dd[DIV_CELLS].len >> SHIFT;
      rsp_in.result_tag = dd[DIV_CELLS].tag;
      if (dd[DIV_CELLS].len == '0) begin
         rsp_in.normal_x   = '0;
         rsp_in.normal_y   = '0;
         rsp_in.normal_z   = '0;
         rsp_in.area       = '0;
         rsp_in.degenerate = 1'b1;
      end else begin
         rsp_in.normal_x   = nrm[0];
         rsp_in.normal_y   = nrm[1];
         rsp_in.normal_z   = nrm[2];
         rsp_in.area       = (len_sh[ROOT_W-1:AREA_W] != '0) ? '1 : len_sh[AREA_W-1:0];
         rsp_in.degenerate = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= dv[DIV_CELLS];
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

>>> rtl/tfna_checker.sv
// port-level checks for the triangle face normal and area unit, bound to the top level
// depends on tfna_pkg and triangle_face_normal_area_unit
module tfna_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input tfna_pkg::rsp_type rsp
);
   import tfna_pkg::*;

   localparam logic signed [NORM_W-1:0] ONE_Q30 = NORM_W'(1) << NORM_FRAC;

   a_never_busy: assert property (@(posedge clock) disable iff (reset)
      !busy) else $error("busy raised");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid) else $error("result missing");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |-> ##LATENCY !rsp_valid) else $error("unrequested result");

   a_degenerate_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp.degenerate) |-> (rsp.normal_x == '0 && rsp.normal_y == '0
         && rsp.normal_z == '0 && rsp.area == '0)) else $error("degenerate not zero");

   a_normal_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp.normal_x <= ONE_Q30 && rsp.normal_x >= -ONE_Q30
         && rsp.normal_y <= ONE_Q30 && rsp.normal_y >= -ONE_Q30
         && rsp.normal_z <= ONE_Q30 && rsp.normal_z >= -ONE_Q30))
      else $error("normal out of range");

endmodule

bind triangle_face_normal_area_unit tfna_checker u_tfna_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp       (rsp)
);

>>> tb/sv/triangle_face_normal_area_unit_tb.sv
// self-checking testbench for triangle_face_normal_area_unit: directed and random triangles
// depends on tfna_pkg and the triangle_face_normal_area_unit rtl
`timescale 1ns / 100ps

module triangle_face_normal_area_unit_tb;
   import tfna_pkg::*;

   localparam int FB        = FRACTION_BITS_DEF;
   localparam int N_RANDOM  = 1450;
   localparam int MAX_CYCLE = 400000;

   class face_scoreboard;
      rsp_type pending[$];
      int      mismatches = 0;

      // exact cross product, integer square root, rounded unit normal
      function automatic rsp_type face_result(req_type r);
         logic signed [33:0]  e1x, e1y, e1z, e2x, e2y, e2z;
         logic signed [69:0]  nx, ny, nz;
         logic [69:0]         mx, my, mz, len;
         logic [139:0]        sum, rem, res, bitv, trial;
         logic [111:0]        num, q2;
         logic [69:0]         area_wide;
         logic [31:0]         q;
         rsp_type             o;
         e1x = r.bx - r.ax;  e1y = r.by_coord - r.ay;  e1z = r.bz - r.az;
         e2x = r.cx - r.ax;  e2y = r.cy - r.ay;        e2z = r.cz - r.az;
         nx = e1y * e2z - e1z * e2y;
         ny = e1z * e2x - e1x * e2z;
         nz = e1x * e2y - e1y * e2x;
         mx = nx < 0 ? -nx : nx;
         my = ny < 0 ? -ny : ny;
         mz = nz < 0 ? -nz : nz;
         sum = mx * mx + my * my + mz * mz;
         rem = sum;
         res = '0;
         bitv = 140'd1 << 138;
         while (bitv != 0) begin
            trial = res + bitv;
            if (rem >= trial) begin
               rem = rem - trial;
               res = (res >> 1) + bitv;
            end else begin
               res = res >> 1;
            end
            bitv = bitv >> 2;
         end
         len = res[69:0];
         o = '0;
         o.result_tag = r.face_tag;
         if (len == 0) begin
            o.degenerate = 1'b1;
         end else begin
            num = mx;  num = num << 31;  q2 = num / len;  q = (q2 + 1) >> 1;
            o.normal_x = nx < 0 ? -q : q;
            num = my;  num = num << 31;  q2 = num / len;  q = (q2 + 1) >> 1;
            o.normal_y = ny < 0 ? -q : q;
            num = mz;  num = num << 31;  q2 = num / len;  q = (q2 + 1) >> 1;
            o.normal_z = nz < 0 ? -q : q;
            area_wide = len >> (FB + 1);
            o.area = (area_wide > 70'hF_FFFF_FFFF_FFFF) ? '1 : area_wide[AREA_W-1:0];
         end
         return o;
      endfunction

      function void note_request(req_type r);
         pending = {pending, face_result(r)};
      endfunction

      function void check_result(rsp_type a);
         rsp_type e;
         if (pending.size() == 0) begin
            $error("result with tag %0d arrived with nothing expected", a.result_tag);
            mismatches++;
            return;
         end
         e = pending.pop_front();
         if (a.result_tag !== e.result_tag) begin
            $error("result_tag expected %0d actual %0d", e.result_tag, a.result_tag);
            mismatches++;
         end
         if (a.normal_x !== e.normal_x) begin
            $error("normal_x expected %0d actual %0d", e.normal_x, a.normal_x);
            mismatches++;
         end
         if (a.normal_y !== e.normal_y) begin
            $error("normal_y expected %0d actual %0d", e.normal_y, a.normal_y);
            mismatches++;
         end
         if (a.normal_z !== e.normal_z) begin
            $error("normal_z expected %0d actual %0d", e.normal_z, a.normal_z);
            mismatches++;
         end
         if (a.area !== e.area) begin
            $error("area expected %0d actual %0d", e.area, a.area);
            mismatches++;
         end
         if (a.degenerate !== e.degenerate) begin
            $error("degenerate expected %0d actual %0d", e.degenerate, a.degenerate);
            mismatches++;
         end
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req = '0;
   logic    rsp_valid;
   rsp_type rsp;

   face_scoreboard faces = new();
   int unsigned    cycle_count = 0;
   int unsigned    burst_left = 0;

   triangle_face_normal_area_unit dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req(req), .rsp_valid(rsp_valid), .rsp(rsp)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > MAX_CYCLE) begin
         $display("triangle_face_normal_area_unit_tb NOT OK");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) faces.check_result(rsp);
   end

   function automatic logic [31:0] pick_coord(int mode);
      case (mode)
         0: return $urandom;
         1: return 32'($signed($urandom_range(0, 4000)) - 2000) << FB;
         2: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
         default: return ($urandom_range(0, 1)) ? 32'h7FFF_FFFF : 32'h8000_0000;
      endcase
   endfunction

   // holds the request until accepted; bursts with random gaps between them
   task automatic send_face(req_type r);
      int gap;
      if (burst_left == 0) begin
         start <= 1'b0;
         gap = $urandom_range(1, 12);
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(1, 30);
      end
      burst_left--;
      start <= 1'b1;
      req   <= r;
      do @(posedge clock); while (busy !== 1'b0);
      faces.note_request(r);
   endtask

   task automatic send_coords(logic [15:0] tag, logic [31:0] c[9]);
      req_type r;
      r = {tag, c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], c[8]};
      send_face(r);
   endtask

   initial begin
      logic [31:0] c[9];
      int          mode, k;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // all points equal: degenerate
      c = '{default: 32'h0};
      send_coords(16'h0000, c);
      // right triangle in the xy plane, unit legs
      c = '{0, 0, 0, 1 << FB, 0, 0, 0, 1 << FB, 0};
      send_coords(16'hFFFF, c);
      // same in yz and zx planes, and mirrored
      c = '{0, 0, 0, 0, 1 << FB, 0, 0, 0, 1 << FB};
      send_coords(16'h0001, c);
      c = '{0, 0, 0, 0, 0, 1 << FB, 1 << FB, 0, 0};
      send_coords(16'h8000, c);
      c = '{0, 0, 0, 0, 1 << FB, 0, 1 << FB, 0, 0};
      send_coords(16'h7FFF, c);
      // collinear points: degenerate
      c = '{0, 0, 0, 1, 2, 3, 2, 4, 6};
      send_coords(16'h1234, c);
      // tiny area that floors to zero but is not degenerate
      c = '{0, 0, 0, 1, 0, 0, 0, 1, 0};
      send_coords(16'h0002, c);
      // extreme coordinates and all-equal vertices; the area does not reach saturation
      c = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
            32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
            32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
      send_coords(16'hAAAA, c);
      c = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
            32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
            32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000};
      send_coords(16'h5555, c);
      c = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
            32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
            32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
      send_coords(16'h00FF, c);
      c = '{default: 32'h7FFF_FFFF};
      send_coords(16'hFF00, c);
      c = '{default: 32'h8000_0000};
      send_coords(16'h0F0F, c);
      c = '{default: 32'hFFFF_FFFF};
      send_coords(16'hF0F0, c);
      // isosceles triangle with a negative coordinate
      c = '{-(1 << FB), 0, 0, 1 << FB, 0, 0, 0, 3 << FB, 5 << FB};
      send_coords(16'h0003, c);

      for (int n = 0; n < N_RANDOM; n++) begin
         mode = $urandom_range(0, 9);
         for (int i = 0; i < 9; i++) c[i] = pick_coord(mode % 4);
         if (mode == 8) begin
            // collinear third point from a small multiple of the first edge
            k = $urandom_range(0, 6) - 3;
            for (int i = 0; i < 3; i++) begin
               c[i] = pick_coord(1);
               c[3 + i] = c[i] + pick_coord(1);
               c[6 + i] = c[i] + k * (c[3 + i] - c[i]);
            end
         end else if (mode == 9) begin
            // two coincident vertices
            for (int i = 0; i < 3; i++) c[6 + i] = c[$urandom_range(0, 1) * 3 + i];
         end
         send_coords(16'($urandom), c);
      end
      start <= 1'b0;

      while (faces.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 20) @(posedge clock);
      if (faces.mismatches == 0) begin
         $display("triangle_face_normal_area_unit_tb OK");
      end else begin
         $display("triangle_face_normal_area_unit_tb NOT OK");
      end
      $finish;
   end

endmodule
